>>> rtl/cbz_pkg.sv
// Shared types and fixed field widths for the cubic Bezier point evaluator.
// No dependencies; used by cbz_axis and cubic_bezier_point_eval.
package cbz_pkg;

  localparam int CoordW  = 12;
  localparam int TFracW  = 16;
  localparam int CurveW  = 16;

  typedef struct packed {
    logic [CoordW-1:0] p0_x;
    logic [CoordW-1:0] p0_y;
    logic [CoordW-1:0] p1_x;
    logic [CoordW-1:0] p1_y;
    logic [CoordW-1:0] p2_x;
    logic [CoordW-1:0] p2_y;
    logic [CoordW-1:0] p3_x;
    logic [CoordW-1:0] p3_y;
    logic [TFracW-1:0] t_frac;
  } cbz_item_t;

  typedef struct packed {
    logic [CurveW-1:0] curve_x;
    logic [CurveW-1:0] curve_y;
  } cbz_point_t;

endpackage

>>> rtl/cbz_axis.sv
// One coordinate axis of the Bezier evaluator: four-stage multiply-accumulate datapath.
// Uses cbz_pkg for the result width; the squared weights arrive from the top level.
module cbz_axis #(
  parameter int COORD_BITS    = 12,
  parameter int T_FRAC_BITS   = 16,
  parameter int OUT_FRAC_BITS = 4
) (
  input  logic                         clk_i,
  input  logic [COORD_BITS-1:0]        p0_i,
  input  logic [COORD_BITS-1:0]        p1_i,
  input  logic [COORD_BITS-1:0]        p2_i,
  input  logic [COORD_BITS-1:0]        p3_i,
  input  logic [T_FRAC_BITS-1:0]       t_i,
  input  logic [T_FRAC_BITS:0]         u_i,
  input  logic [2*T_FRAC_BITS:0]       u2_i,
  input  logic [2*T_FRAC_BITS:0]       t2_i,
  output logic [cbz_pkg::CurveW-1:0]   res_o
);

  localparam int C     = COORD_BITS;
  localparam int F     = T_FRAC_BITS;
  localparam int AW    = C + F + 2;
  localparam int U2W   = 2 * F + 1;
  localparam int PW    = 3 * F + C;
  localparam int AL    = AW / 2;
  localparam int AHW   = AW - AL;
  localparam int ML    = U2W / 2;
  localparam int MHW   = U2W - ML;
  localparam int Shift = 3 * F - OUT_FRAC_BITS;

  logic [F+1:0]     t3;
  logic [F+2:0]     u3;
  logic [AW-1:0]    a_d, a_q, b_d, b_q;

  logic [ML+AL-1:0]   ua_ll_q, tb_ll_q;
  logic [ML+AHW-1:0]  ua_lh_q, tb_lh_q;
  logic [MHW+AL-1:0]  ua_hl_q, tb_hl_q;
  logic [MHW+AHW-1:0] ua_hh_q, tb_hh_q;

  logic [PW-1:0]    prod_a_d, prod_a_q, prod_b_d, prod_b_q;
  logic [cbz_pkg::CurveW-1:0] res_d, res_q;

  assign t3  = (F+2)'({t_i, 1'b0}) + (F+2)'(t_i);
  assign u3  = (F+3)'({u_i, 1'b0}) + (F+3)'(u_i);
  assign a_d = AW'(u_i) * AW'(p0_i) + AW'(t3) * AW'(p1_i);
  assign b_d = AW'(u3) * AW'(p2_i) + AW'(t_i) * AW'(p3_i);

  assign prod_a_d = PW'(ua_ll_q) + (PW'(ua_lh_q) << AL) + (PW'(ua_hl_q) << ML)
                  + (PW'(ua_hh_q) << (AL + ML));
  assign prod_b_d = PW'(tb_ll_q) + (PW'(tb_lh_q) << AL) + (PW'(tb_hl_q) << ML)
                  + (PW'(tb_hh_q) << (AL + ML));

  assign res_d = cbz_pkg::CurveW'((prod_a_q + prod_b_q) >> Shift);

  // stage 1: inner weighted pairs
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  // stage 2: split partial products against the squared weights
  always_ff @(posedge clk_i) begin
    ua_ll_q <= (ML+AL)'(u2_i[ML-1:0])    * (ML+AL)'(a_q[AL-1:0]);
    ua_lh_q <= (ML+AHW)'(u2_i[ML-1:0])   * (ML+AHW)'(a_q[AW-1:AL]);
    ua_hl_q <= (MHW+AL)'(u2_i[U2W-1:ML]) * (MHW+AL)'(a_q[AL-1:0]);
    ua_hh_q <= (MHW+AHW)'(u2_i[U2W-1:ML]) * (MHW+AHW)'(a_q[AW-1:AL]);
    tb_ll_q <= (ML+AL)'(t2_i[ML-1:0])    * (ML+AL)'(b_q[AL-1:0]);
    tb_lh_q <= (ML+AHW)'(t2_i[ML-1:0])   * (ML+AHW)'(b_q[AW-1:AL]);
    tb_hl_q <= (MHW+AL)'(t2_i[U2W-1:ML]) * (MHW+AL)'(b_q[AL-1:0]);
    tb_hh_q <= (MHW+AHW)'(t2_i[U2W-1:ML]) * (MHW+AHW)'(b_q[AW-1:AL]);
  end

  // stage 3: recombine partials; stage 4: sum and truncate
  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator, Bernstein form, exact sum with one final truncation.
// The done strobe rises together with the result of each start transfer; one item per cycle.
// Four register stages: weighted pairs and squares, split partial products, recombine, sum.
// busy never rises and results cannot be held off. Reset clears the valid bits only.
// Depends on cbz_pkg and cbz_axis.
module cubic_bezier_point_eval #(
  parameter int COORD_BITS    = 12,
  parameter int T_FRAC_BITS   = 16,
  parameter int OUT_FRAC_BITS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  cbz_pkg::cbz_item_t  item_i,
  output logic                busy,
  output logic                done_o,
  output cbz_pkg::cbz_point_t result_o
);

  localparam int C     = COORD_BITS;
  localparam int F     = T_FRAC_BITS;
  localparam int U2W   = 2 * F + 1;
  localparam int Depth = 4;
  localparam logic [F:0] One = (F+1)'(1) << F;

  logic [Depth-1:0] vld_d, vld_q;
  logic [F-1:0]     t;
  logic [F:0]       u;
  logic [U2W-1:0]   u2_d, u2_q, t2_d, t2_q;

  assign busy = 1'b0;
  assign t    = F'(item_i.t_frac);
  assign u    = One - (F+1)'(t);
  assign u2_d = U2W'(u) * U2W'(u);
  assign t2_d = U2W'(t) * U2W'(t);

  assign vld_d = {vld_q[Depth-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u2_q <= u2_d;
    t2_q <= t2_d;
  end

  cbz_axis #(
    .COORD_BITS   (COORD_BITS),
    .T_FRAC_BITS  (T_FRAC_BITS),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_axis_x (
    .clk_i(clk_i),
    .p0_i (C'(item_i.p0_x)),
    .p1_i (C'(item_i.p1_x)),
    .p2_i (C'(item_i.p2_x)),
    .p3_i (C'(item_i.p3_x)),
    .t_i  (t),
    .u_i  (u),
    .u2_i (u2_q),
    .t2_i (t2_q),
    .res_o(result_o.curve_x)
  );

  cbz_axis #(
    .COORD_BITS   (COORD_BITS),
    .T_FRAC_BITS  (T_FRAC_BITS),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_axis_y (
    .clk_i(clk_i),
    .p0_i (C'(item_i.p0_y)),
    .p1_i (C'(item_i.p1_y)),
    .p2_i (C'(item_i.p2_y)),
    .p3_i (C'(item_i.p3_y)),
    .t_i  (t),
    .u_i  (u),
    .u2_i (u2_q),
    .t2_i (t2_q),
    .res_o(result_o.curve_y)
  );

  assign done_o = vld_q[Depth-1];

endmodule
